### hw/rtl/gdad_pkg.sv
// Shared constants, field widths and calendar helpers for the date arithmetic block.
`default_nettype none

package gdad_pkg;

    // Field widths.
    localparam int ACT_W    = 2;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int SERIAL_W = 22;
    localparam int ERR_W    = 2;

    // Stream data widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 56;

    // Shared multiplier operand width.
    localparam int MUL_W = 22;

    // Actions.
    localparam logic [ACT_W-1:0] ACT_ADD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SUB  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DIFF = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CMP  = 2'd3;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_INVALID = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE   = 2'd2;

    localparam logic [YEAR_W-1:0]   MAX_YEAR      = 14'd9999;
    localparam logic [MONTH_W-1:0]  DEC           = 4'd12;
    localparam logic [SERIAL_W-1:0] MAX_SERIAL    = 22'd3652058; // 9999-12-31
    localparam logic [8:0]          DAYS_PER_YEAR = 9'd365;

    // floor(x * RECIP100 / 2^19) equals floor(x / 100) for every 14-bit x.
    localparam logic [MUL_W-1:0] RECIP100   = 22'd5243;
    localparam logic [MUL_W-1:0] MUL365     = 22'd365;
    // Close to 400 / 146097 scaled by 2^30; gives a year estimate within a year or so.
    localparam logic [MUL_W-1:0] RECIP_YEAR = 22'd2939772;
    localparam logic [6:0]       CENTURY    = 7'd100;

    // Length of a month; months outside 1..12 never reach a use of this value.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/gregorian_date_add_diff.sv
// Top level of the Gregorian calendar date arithmetic block.
//
// One request on the s_ channel carries an action, a base date, a second date
// and a day offset. The block adds or subtracts the offset, gives the absolute
// day difference between the dates, or compares them, and returns one request
// on the m_ channel. Dates are mapped to serial day numbers (0001-01-01 is 0).
//
// Timing: one request at a time. s_tready is high only while the sequencer is
// idle. A request with an invalid base date ends at its validity check; the
// time any other request takes is set by the shared year unit (states S_YA to
// S_YD for each pass through its single multiplier, one pass per date and one
// or two more when a serial number is turned back into a year) and by the month
// walks, one month per cycle through a shared adder.
//
// The finished request sits in the m_ output register; the sequencer already
// takes the next request while it waits, and only holds its own final state
// if a second result is ready before the first is taken. Reset (aresetn low,
// synchronous) returns the sequencer to idle and drops m_tvalid.
`default_nettype none

module gregorian_date_add_diff (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata, from bit 0 up: action[2], base_year[14], base_month[4],
    // base_day[5], other_year[14], other_month[4], other_day[5],
    // day_offset[22], zero padding[2].
    input  wire logic [gdad_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata, from bit 0 up: result_year[14], result_month[4], result_day[5],
    // day_distance[22], base_is_earlier[1], dates_equal[1], error_code[2],
    // zero padding[7].
    output logic [gdad_pkg::OUT_TDATA_W-1:0]        m_tdata
);
    import gdad_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_YA    = 4'd1;   // year unit: p / 100
    localparam logic [3:0] S_YB    = 4'd2;   // year unit: 365 * p
    localparam logic [3:0] S_YC    = 4'd3;   // year unit: start of year, y / 100
    localparam logic [3:0] S_YD    = 4'd4;   // year unit: leap flag
    localparam logic [3:0] S_CHK   = 4'd5;   // validity check or year adjust
    localparam logic [3:0] S_MSUM  = 4'd6;   // sum the months before this one
    localparam logic [3:0] S_SDONE = 4'd7;   // serial number complete
    localparam logic [3:0] S_ARITH = 4'd8;   // add or subtract with saturation
    localparam logic [3:0] S_EST0  = 4'd9;   // multiply serial by year reciprocal
    localparam logic [3:0] S_EST   = 4'd10;  // first year estimate
    localparam logic [3:0] S_MDIV  = 4'd11;  // peel whole months off the remainder
    localparam logic [3:0] S_DONE  = 4'd12;  // hand the result to the output register

    // What the year unit is working for.
    localparam logic [1:0] PH_BASE  = 2'd0;
    localparam logic [1:0] PH_OTHER = 2'd1;
    localparam logic [1:0] PH_CONV  = 2'd2;

    logic [3:0]             state_reg, state_next;
    logic [1:0]             phase_reg, phase_next;

    // Request fields.
    logic [ACT_W-1:0]       act_reg, act_next;
    logic [YEAR_W-1:0]      by_reg, by_next;
    logic [MONTH_W-1:0]     bm_reg, bm_next;
    logic [DAY_W-1:0]       bd_reg, bd_next;
    logic [YEAR_W-1:0]      oy_reg, oy_next;
    logic [MONTH_W-1:0]     om_reg, om_next;
    logic [DAY_W-1:0]       od_reg, od_next;
    logic [SERIAL_W-1:0]    off_reg, off_next;

    // Working date and serial arithmetic.
    logic [YEAR_W-1:0]      yr_reg, yr_next;
    logic [MONTH_W-1:0]     mo_reg, mo_next;
    logic [DAY_W-1:0]       dy_reg, dy_next;
    logic [MONTH_W-1:0]     cnt_reg, cnt_next;
    logic [SERIAL_W-1:0]    acc_reg, acc_next;
    logic [SERIAL_W-1:0]    sb_reg, sb_next;
    logic [SERIAL_W-1:0]    ys_reg, ys_next;
    logic [7:0]             q100_reg, q100_next;
    logic                   leap_reg, leap_next;

    // Shared multiplier.
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [2*MUL_W-1:0]     mul_reg;

    // Result fields.
    logic [SERIAL_W-1:0]    dist_reg, dist_next;
    logic                   earlier_reg, earlier_next;
    logic                   equal_reg, equal_next;
    logic [ERR_W-1:0]       err_reg, err_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Combinational helpers.
    logic [YEAR_W-1:0]      p_year;
    logic [7:0]             qy;
    logic                   date_valid;
    logic [SERIAL_W-1:0]    year_rem;
    logic [YEAR_W-1:0]      year_est;
    logic                   pass_base;
    logic [YEAR_W-1:0]      out_year;
    logic [MONTH_W-1:0]     out_month;
    logic [DAY_W-1:0]       out_day;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign p_year   = yr_reg - 14'd1;
    assign qy       = mul_reg[26:19];
    assign year_rem = acc_reg - ys_reg;
    assign year_est = mul_reg[43:30];

    assign date_valid = (yr_reg >= 14'd1) && (yr_reg <= MAX_YEAR)
                     && (mo_reg >= 4'd1) && (mo_reg <= DEC)
                     && (dy_reg >= 5'd1) && (dy_reg <= month_days(mo_reg, leap_reg));

    // Difference, compare and invalid dates return the base date as given.
    assign pass_base = act_reg[1] || (err_reg == ERR_INVALID);
    assign out_year  = pass_base ? by_reg : yr_reg;
    assign out_month = pass_base ? bm_reg : mo_reg;
    assign out_day   = pass_base ? bd_reg : dy_reg;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        act_next      = act_reg;
        by_next       = by_reg;
        bm_next       = bm_reg;
        bd_next       = bd_reg;
        oy_next       = oy_reg;
        om_next       = om_reg;
        od_next       = od_reg;
        off_next      = off_reg;
        yr_next       = yr_reg;
        mo_next       = mo_reg;
        dy_next       = dy_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        sb_next       = sb_reg;
        ys_next       = ys_reg;
        q100_next     = q100_reg;
        leap_next     = leap_reg;
        dist_next     = dist_reg;
        earlier_next  = earlier_reg;
        equal_next    = equal_reg;
        err_next      = err_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mul_a         = '0;
        mul_b         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next     = s_tdata[1:0];
                    by_next      = s_tdata[15:2];
                    bm_next      = s_tdata[19:16];
                    bd_next      = s_tdata[24:20];
                    oy_next      = s_tdata[38:25];
                    om_next      = s_tdata[42:39];
                    od_next      = s_tdata[47:43];
                    off_next     = s_tdata[69:48];
                    yr_next      = s_tdata[15:2];
                    mo_next      = s_tdata[19:16];
                    dy_next      = s_tdata[24:20];
                    phase_next   = PH_BASE;
                    err_next     = ERR_OK;
                    dist_next    = '0;
                    earlier_next = 1'b0;
                    equal_next   = 1'b0;
                    state_next   = S_YA;
                end
            end
            S_YA: begin
                mul_a      = MUL_W'(p_year);
                mul_b      = RECIP100;
                state_next = S_YB;
            end
            S_YB: begin
                q100_next  = mul_reg[26:19];
                mul_a      = MUL_W'(p_year);
                mul_b      = MUL365;
                state_next = S_YC;
            end
            S_YC: begin
                // Days before January 1: 365p + p/4 - p/100 + p/400.
                ys_next    = mul_reg[SERIAL_W-1:0] + SERIAL_W'(p_year >> 2)
                           - SERIAL_W'(q100_reg) + SERIAL_W'(q100_reg >> 2);
                mul_a      = MUL_W'(yr_reg);
                mul_b      = RECIP100;
                state_next = S_YD;
            end
            S_YD: begin
                leap_next  = (yr_reg[1:0] == 2'b00)
                          && ((yr_reg != (YEAR_W'(qy) * YEAR_W'(CENTURY)))
                              || (qy[1:0] == 2'b00));
                state_next = S_CHK;
            end
            S_CHK: begin
                if (phase_reg == PH_CONV) begin
                    if (ys_reg > acc_reg) begin
                        yr_next    = yr_reg - 14'd1;
                        state_next = S_YA;
                    end else if ((yr_reg < MAX_YEAR)
                              && (year_rem >= SERIAL_W'(DAYS_PER_YEAR + 9'(leap_reg)))) begin
                        yr_next    = yr_reg + 14'd1;
                        state_next = S_YA;
                    end else begin
                        acc_next   = year_rem;
                        mo_next    = 4'd1;
                        state_next = S_MDIV;
                    end
                end else if (!date_valid) begin
                    err_next   = ERR_INVALID;
                    state_next = S_DONE;
                end else begin
                    acc_next   = ys_reg;
                    cnt_next   = 4'd1;
                    state_next = S_MSUM;
                end
            end
            S_MSUM: begin
                if (cnt_reg < mo_reg) begin
                    acc_next = acc_reg + SERIAL_W'(month_days(cnt_reg, leap_reg));
                    cnt_next = cnt_reg + 4'd1;
                end else begin
                    acc_next   = acc_reg + SERIAL_W'(dy_reg) - 22'd1;
                    state_next = S_SDONE;
                end
            end
            S_SDONE: begin
                if (phase_reg == PH_BASE) begin
                    sb_next = acc_reg;
                    if (!act_reg[1]) begin
                        state_next = S_ARITH;
                    end else begin
                        yr_next    = oy_reg;
                        mo_next    = om_reg;
                        dy_next    = od_reg;
                        phase_next = PH_OTHER;
                        state_next = S_YA;
                    end
                end else begin
                    if (act_reg == ACT_DIFF) begin
                        dist_next = (sb_reg > acc_reg) ? (sb_reg - acc_reg)
                                                       : (acc_reg - sb_reg);
                    end else begin
                        earlier_next = (sb_reg < acc_reg);
                        equal_next   = (sb_reg == acc_reg);
                    end
                    state_next = S_DONE;
                end
            end
            S_ARITH: begin
                if (act_reg == ACT_ADD) begin
                    if (off_reg > (MAX_SERIAL - sb_reg)) begin
                        acc_next = MAX_SERIAL;
                        err_next = ERR_RANGE;
                    end else begin
                        acc_next = sb_reg + off_reg;
                    end
                end else begin
                    if (off_reg > sb_reg) begin
                        acc_next = '0;
                        err_next = ERR_RANGE;
                    end else begin
                        acc_next = sb_reg - off_reg;
                    end
                end
                state_next = S_EST0;
            end
            S_EST0: begin
                mul_a      = acc_reg;
                mul_b      = RECIP_YEAR;
                state_next = S_EST;
            end
            S_EST: begin
                yr_next    = (year_est >= MAX_YEAR) ? MAX_YEAR : (year_est + 14'd1);
                phase_next = PH_CONV;
                state_next = S_YA;
            end
            S_MDIV: begin
                if ((mo_reg < DEC) && (acc_reg >= SERIAL_W'(month_days(mo_reg, leap_reg)))) begin
                    acc_next = acc_reg - SERIAL_W'(month_days(mo_reg, leap_reg));
                    mo_next  = mo_reg + 4'd1;
                end else begin
                    dy_next    = acc_reg[DAY_W-1:0] + 5'd1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {7'd0, err_reg, equal_reg, earlier_reg, dist_reg,
                                     out_day, out_month, out_year};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_BASE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        by_reg      <= by_next;
        bm_reg      <= bm_next;
        bd_reg      <= bd_next;
        oy_reg      <= oy_next;
        om_reg      <= om_next;
        od_reg      <= od_next;
        off_reg     <= off_next;
        yr_reg      <= yr_next;
        mo_reg      <= mo_next;
        dy_reg      <= dy_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        sb_reg      <= sb_next;
        ys_reg      <= ys_next;
        q100_reg    <= q100_next;
        leap_reg    <= leap_next;
        mul_reg     <= mul_a * mul_b;
        dist_reg    <= dist_next;
        earlier_reg <= earlier_next;
        equal_reg   <= equal_next;
        err_reg     <= err_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Checks on the sequencer and on the results it produces.
    logic [ERR_W-1:0]    chk_err;
    logic [SERIAL_W-1:0] chk_dist;
    logic                chk_earlier;
    logic                chk_equal;

    assign chk_err     = m_tdata_reg[48:47];
    assign chk_dist    = m_tdata_reg[44:23];
    assign chk_earlier = m_tdata_reg[45];
    assign chk_equal   = m_tdata_reg[46];

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (chk_err == ERR_OK) || (chk_err == ERR_INVALID)
                      || (chk_err == ERR_RANGE))
        else $error("error code outside the defined set");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(chk_earlier && chk_equal))
        else $error("earlier and equal flags both set");

    a_invalid_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (chk_err == ERR_INVALID))
            |-> (chk_dist == '0) && !chk_earlier && !chk_equal)
        else $error("invalid date left a distance or compare flag");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while the previous one is in progress");

    a_month_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MDIV) |-> (mo_reg >= 4'd1) && (mo_reg <= DEC))
        else $error("month walk left the range of months");

endmodule

`default_nettype wire
